[hdl/ctlru_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctlru_pkg
// Shared constants, register codes and controller/datapath interface types
// for the cache and TLB LRU miss tracker.
// ----------------------------------------------------------------------------
package ctlru_pkg;

  localparam int MAX_CACHE_SETS = 1024;
  localparam int MAX_CACHE_WAYS = 16;
  localparam int MAX_TLB_SETS   = 64;
  localparam int MAX_TLB_WAYS   = 8;

  localparam int ADDR_W    = 48;
  localparam int STAMP_W   = 32;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;

  localparam int MAX_SETS = (MAX_CACHE_SETS > MAX_TLB_SETS) ? MAX_CACHE_SETS : MAX_TLB_SETS;
  localparam int MAX_WAYS = (MAX_CACHE_WAYS > MAX_TLB_WAYS) ? MAX_CACHE_WAYS : MAX_TLB_WAYS;

  localparam int DIV_W  = $clog2(MAX_SETS + 1);
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAYC_W = $clog2(MAX_WAYS + 1);
  localparam int DCNT_W = $clog2(ADDR_W);

  localparam int CENT    = MAX_CACHE_SETS * MAX_CACHE_WAYS;
  localparam int TENT    = MAX_TLB_SETS * MAX_TLB_WAYS;
  localparam int CADDR_W = (CENT > 1) ? $clog2(CENT) : 1;
  localparam int TADDR_W = (TENT > 1) ? $clog2(TENT) : 1;
  localparam int ENT_W   = 1 + STAMP_W + ADDR_W;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_LOG2 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CSETS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CWAYS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_LOG2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TSETS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TWAYS     = 3'd5;

  typedef struct packed {
    logic clr;
    logic accept;
    logic div_step;
    logic rd;
    logic cmp;
    logic wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cfg_clr;
    logic clr_last;
    logic div_last;
    logic way_last;
    logic sel_cache;
  } sts_t;

endpackage

[hdl/ctlru_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctlru_ctrl
// Sequencer: clearing sweep, accept, divide, way scan, update, result.
// ----------------------------------------------------------------------------
module ctlru_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  ctlru_pkg::sts_t  sts,
  output ctlru_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_DIV, S_RD, S_CMP, S_WR, S_DONE} state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.clr      = (state_r == S_CLR);
    cmd.accept   = (state_r == S_IDLE) && in_valid;
    cmd.div_step = (state_r == S_DIV);
    cmd.rd       = (state_r == S_RD);
    cmd.cmp      = (state_r == S_CMP);
    cmd.wr       = (state_r == S_WR);
    cmd.out_load = (state_r == S_DONE) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load && !sts.cfg_clr) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (sts.cfg_clr) begin
        state_r <= S_CLR;
      end else begin
        unique case (state_r)
          S_CLR:  if (sts.clr_last) state_r <= S_IDLE;
          S_IDLE: if (in_valid) state_r <= S_DIV;
          S_DIV:  if (sts.div_last) state_r <= S_RD;
          S_RD:   state_r <= S_CMP;
          S_CMP:  state_r <= sts.way_last ? S_WR : S_RD;
          S_WR:   state_r <= sts.sel_cache ? S_DONE : S_DIV;
          S_DONE: if (slot_free) state_r <= S_IDLE;
          default: state_r <= S_CLR;
        endcase
      end
    end
  end

  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && !sts.cfg_clr) |=> state_r == S_DIV)
    else $error("accepted transaction did not start divide");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result loaded over a stalled result");

  a_tlb_then_cache: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR && !sts.sel_cache && !sts.cfg_clr) |=> state_r == S_DIV)
    else $error("cache lookup did not follow TLB update");

endmodule

[hdl/ctlru_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctlru_dp
// Datapath: config registers, serial divider, tag/stamp memories, way scan,
// counters and result registers.
// ----------------------------------------------------------------------------
module ctlru_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ctlru_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ctlru_pkg::CFG_W-1:0]        cfg_data,
  input  logic [ctlru_pkg::ADDR_W-1:0]       in_address,
  output logic                               out_tlb_missed,
  output logic                               out_cache_missed,
  output logic [ctlru_pkg::STAMP_W-1:0]      out_accesses_so_far,
  output logic [ctlru_pkg::STAMP_W-1:0]      out_tlb_misses_so_far,
  output logic [ctlru_pkg::STAMP_W-1:0]      out_cache_misses_so_far,
  input  ctlru_pkg::cmd_t                    cmd,
  output ctlru_pkg::sts_t                    sts
);

  localparam int AW = ctlru_pkg::ADDR_W;
  localparam int SW = ctlru_pkg::STAMP_W;
  localparam int DW = ctlru_pkg::DIV_W;
  localparam int WW = ctlru_pkg::WAY_W;
  localparam int CW = ctlru_pkg::WAYC_W;

  logic [3:0]  line_log2_r;
  logic [10:0] csets_r;
  logic [4:0]  cways_r;
  logic [4:0]  page_log2_r;
  logic [6:0]  tsets_r;
  logic [3:0]  tways_r;

  logic [AW-1:0] addr_r;
  logic [SW-1:0] acc_r, tmc_r, cmc_r;
  logic          sel_r;
  logic [AW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [ctlru_pkg::DCNT_W-1:0] dcnt_r;
  logic [WW-1:0] way_r, hway_r, vic_r;
  logic          hit_r, tmiss_r, cmiss_r;
  logic [SW-1:0] vstamp_r;
  logic [ctlru_pkg::CADDR_W-1:0] clr_r;

  logic [ctlru_pkg::ENT_W-1:0] cmem [ctlru_pkg::CENT];
  logic [ctlru_pkg::ENT_W-1:0] tmem [ctlru_pkg::TENT];
  logic [ctlru_pkg::ENT_W-1:0] crd_r, trd_r;

  logic [DW-1:0] csets, tsets, sets;
  logic [CW-1:0] cways, tways, ways;
  logic [WW-1:0] ways_m1, aw_way;
  logic [AW-1:0] key_tlb, key_cache;
  logic [DW:0]   trial;
  logic          q_bit;
  logic [ctlru_pkg::CADDR_W-1:0] caddr;
  logic [ctlru_pkg::TADDR_W-1:0] taddr;
  logic [ctlru_pkg::ENT_W-1:0]   rdata, wentry;
  logic          r_valid, match;
  logic [SW-1:0] r_stamp;
  logic [AW-1:0] r_tag;

  always_comb begin
    if (csets_r == '0) csets = DW'(1);
    else if (csets_r > 11'(ctlru_pkg::MAX_CACHE_SETS)) csets = DW'(ctlru_pkg::MAX_CACHE_SETS);
    else csets = DW'(csets_r);
    if (tsets_r == '0) tsets = DW'(1);
    else if (tsets_r > 7'(ctlru_pkg::MAX_TLB_SETS)) tsets = DW'(ctlru_pkg::MAX_TLB_SETS);
    else tsets = DW'(tsets_r);
    if (cways_r == '0) cways = CW'(1);
    else if (cways_r > 5'(ctlru_pkg::MAX_CACHE_WAYS)) cways = CW'(ctlru_pkg::MAX_CACHE_WAYS);
    else cways = CW'(cways_r);
    if (tways_r == '0) tways = CW'(1);
    else if (tways_r > 4'(ctlru_pkg::MAX_TLB_WAYS)) tways = CW'(ctlru_pkg::MAX_TLB_WAYS);
    else tways = CW'(tways_r);
  end

  assign sets      = sel_r ? csets : tsets;
  assign ways      = sel_r ? cways : tways;
  assign ways_m1   = WW'(ways - CW'(1));
  assign key_tlb   = in_address >> page_log2_r;
  assign key_cache = addr_r >> line_log2_r;

  assign trial = {rem_r, quo_r[AW-1]};
  assign q_bit = (trial >= {1'b0, sets});

  assign aw_way = cmd.wr ? (hit_r ? hway_r : vic_r) : way_r;
  assign caddr  = ctlru_pkg::CADDR_W'(rem_r) * ctlru_pkg::CADDR_W'(ctlru_pkg::MAX_CACHE_WAYS)
                + ctlru_pkg::CADDR_W'(aw_way);
  assign taddr  = ctlru_pkg::TADDR_W'(rem_r) * ctlru_pkg::TADDR_W'(ctlru_pkg::MAX_TLB_WAYS)
                + ctlru_pkg::TADDR_W'(aw_way);

  assign rdata   = sel_r ? crd_r : trd_r;
  assign r_valid = rdata[ctlru_pkg::ENT_W-1];
  assign r_stamp = rdata[AW +: SW];
  assign r_tag   = rdata[AW-1:0];
  assign match   = r_valid && (r_tag == quo_r);
  assign wentry  = {1'b1, acc_r, quo_r};

  assign sts.cfg_clr   = cfg_we && (cfg_index <= ctlru_pkg::REG_TWAYS);
  assign sts.clr_last  = (clr_r == ctlru_pkg::CADDR_W'(ctlru_pkg::CENT - 1));
  assign sts.div_last  = (dcnt_r == ctlru_pkg::DCNT_W'(AW - 1));
  assign sts.way_last  = (way_r == ways_m1);
  assign sts.sel_cache = sel_r;

  always_ff @(posedge clk) begin
    if (cmd.clr) cmem[clr_r] <= '0;
    else if (cmd.wr && sel_r) cmem[caddr] <= wentry;
    if (cmd.rd && sel_r) crd_r <= cmem[caddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      if (clr_r < ctlru_pkg::CADDR_W'(ctlru_pkg::TENT))
        tmem[ctlru_pkg::TADDR_W'(clr_r)] <= '0;
    end else if (cmd.wr && !sel_r) begin
      tmem[taddr] <= wentry;
    end
    if (cmd.rd && !sel_r) trd_r <= tmem[taddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_log2_r <= 4'd6;
      csets_r     <= 11'd1024;
      cways_r     <= 5'd4;
      page_log2_r <= 5'd12;
      tsets_r     <= 7'd16;
      tways_r     <= 4'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ctlru_pkg::REG_LINE_LOG2: line_log2_r <= cfg_data[3:0];
        ctlru_pkg::REG_CSETS:     csets_r     <= cfg_data[10:0];
        ctlru_pkg::REG_CWAYS:     cways_r     <= cfg_data[4:0];
        ctlru_pkg::REG_PAGE_LOG2: page_log2_r <= cfg_data[4:0];
        ctlru_pkg::REG_TSETS:     tsets_r     <= cfg_data[6:0];
        ctlru_pkg::REG_TWAYS:     tways_r     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || sts.cfg_clr) begin
      acc_r <= '0;
      tmc_r <= '0;
      cmc_r <= '0;
      clr_r <= '0;
      sel_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_r <= clr_r + 1'b1;
      if (cmd.accept) begin
        addr_r <= in_address;
        acc_r  <= acc_r + 1'b1;
        sel_r  <= 1'b0;
        quo_r  <= key_tlb;
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      if (cmd.div_step) begin
        rem_r  <= q_bit ? DW'(trial - {1'b0, sets}) : trial[DW-1:0];
        quo_r  <= {quo_r[AW-2:0], q_bit};
        dcnt_r <= dcnt_r + 1'b1;
        if (sts.div_last) begin
          way_r <= '0;
          hit_r <= 1'b0;
        end
      end
      if (cmd.cmp) begin
        if (match && !hit_r) begin
          hit_r  <= 1'b1;
          hway_r <= way_r;
        end
        if (way_r == '0 || r_stamp < vstamp_r) begin
          vstamp_r <= r_stamp;
          vic_r    <= way_r;
        end
        way_r <= way_r + 1'b1;
      end
      if (cmd.wr) begin
        if (sel_r) begin
          cmiss_r <= !hit_r;
          if (!hit_r) cmc_r <= cmc_r + 1'b1;
        end else begin
          tmiss_r <= !hit_r;
          if (!hit_r) tmc_r <= tmc_r + 1'b1;
          sel_r  <= 1'b1;
          quo_r  <= key_cache;
          rem_r  <= '0;
          dcnt_r <= '0;
        end
      end
      if (cmd.out_load) begin
        out_tlb_missed          <= tmiss_r;
        out_cache_missed        <= cmiss_r;
        out_accesses_so_far     <= acc_r;
        out_tlb_misses_so_far   <= tmc_r;
        out_cache_misses_so_far <= cmc_r;
      end
    end
  end

endmodule

[hdl/cache_and_tlb_lru_miss_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cache_and_tlb_lru_miss_tracker
// Set-associative TLB and data cache LRU miss tracker (top level).
//
//   channel  ports                          direction
//   input    in_valid/in_stall, in_address  in
//   result   out_valid/out_stall, out_*     out
//   config   cfg_we, cfg_index, cfg_data    in
//
// A transaction looks up the TLB, then the cache: each table runs a 48-step
// one-bit-per-cycle divider for set and tag, scans its ways through one
// registered memory read port, then updates.
// After reset and after each register write a clearing pass over the tag
// memories runs; no input is taken meanwhile.
// A finished result waits in the output register while the next input runs.
// ----------------------------------------------------------------------------
module cache_and_tlb_lru_miss_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ctlru_pkg::ADDR_W-1:0]    in_address,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_tlb_missed,
  output logic                            out_cache_missed,
  output logic [ctlru_pkg::STAMP_W-1:0]   out_accesses_so_far,
  output logic [ctlru_pkg::STAMP_W-1:0]   out_tlb_misses_so_far,
  output logic [ctlru_pkg::STAMP_W-1:0]   out_cache_misses_so_far,
  input  logic                            cfg_we,
  input  logic [ctlru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ctlru_pkg::CFG_W-1:0]     cfg_data
);

  ctlru_pkg::cmd_t cmd;
  ctlru_pkg::sts_t sts;

  ctlru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ctlru_dp u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_address              (in_address),
    .out_tlb_missed          (out_tlb_missed),
    .out_cache_missed        (out_cache_missed),
    .out_accesses_so_far     (out_accesses_so_far),
    .out_tlb_misses_so_far   (out_tlb_misses_so_far),
    .out_cache_misses_so_far (out_cache_misses_so_far),
    .cmd                     (cmd),
    .sts                     (sts)
  );

endmodule
